[sv/ertp_pkg.sv]
// ertp_pkg: shared types, widths, register codes and the cordic arctangent table
// for the euler rotate/translate points unit; no dependencies
package ertp_pkg;

  localparam int POINT_W   = 32;
  localparam int COEF_W    = 18;
  localparam int COEF_FRAC = COEF_W - 2;
  localparam int ANG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // cordic working format: q30 with headroom for the raw +-4 rad angle range
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_STEPS = 30;
  localparam int ITER_W       = 5;

  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [ANG_W-1:0]    angle_t;
  typedef logic signed [POINT_W-1:0]  point_t;
  typedef logic signed [CORDIC_W-1:0] cord_t;

  typedef struct packed {
    point_t x_in;
    point_t y_in;
    point_t z_in;
  } pt_in_t;

  typedef struct packed {
    point_t x_out;
    point_t y_out;
    point_t z_out;
    logic   overflow;
  } pt_out_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_X = 3'd0,
    REG_ANGLE_Y = 3'd1,
    REG_ANGLE_Z = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5
  } cfg_reg_e;

  // arctangent of 2^-i in q30
  function automatic cord_t atan_q30(input logic [ITER_W-1:0] i);
    cord_t r;
    case (i)
      5'd0:    r = 34'sd843314857;
      5'd1:    r = 34'sd497837829;
      5'd2:    r = 34'sd263043836;
      5'd3:    r = 34'sd133525159;
      5'd4:    r = 34'sd67021687;
      5'd5:    r = 34'sd33543516;
      5'd6:    r = 34'sd16775851;
      5'd7:    r = 34'sd8388437;
      5'd8:    r = 34'sd4194283;
      5'd9:    r = 34'sd2097149;
      5'd10:   r = 34'sd1048575;
      5'd11:   r = 34'sd524287;
      5'd12:   r = 34'sd262143;
      5'd13:   r = 34'sd131071;
      5'd14:   r = 34'sd65535;
      5'd15:   r = 34'sd32767;
      5'd16:   r = 34'sd16383;
      5'd17:   r = 34'sd8191;
      5'd18:   r = 34'sd4095;
      5'd19:   r = 34'sd2047;
      5'd20:   r = 34'sd1023;
      5'd21:   r = 34'sd511;
      5'd22:   r = 34'sd255;
      5'd23:   r = 34'sd127;
      5'd24:   r = 34'sd63;
      5'd25:   r = 34'sd31;
      5'd26:   r = 34'sd15;
      5'd27:   r = 34'sd8;
      5'd28:   r = 34'sd4;
      5'd29:   r = 34'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[sv/euler_rotate_translate_points_unit.sv]
// euler_rotate_translate_points_unit: top level, config registers and the
// three-stage point transform pipeline; depends on ertp_pkg and ertp_matrix
//
// Transforms one Q16.16 point per transaction to R*p + t, rounded and saturated.
// Points stream at one per cycle unless output stall or a rebuild holds them,
// through three registered stages (multiply, row sum, round/saturate); each
// stage holds its item under output stall and bubbles collapse. After reset
// and after every angle write the rotation matrix is rebuilt by a shared
// iterative cordic (one run per angle) and fourteen multiplies on one 18x18
// multiplier plus a final sum; input and config writes are stalled meanwhile.
module euler_rotate_translate_points_unit import ertp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pt_in_t               in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pt_out_t              out_data_o
);

  localparam int MPROD_W = COEF_W + POINT_W;
  localparam int ACC_W   = MPROD_W + 3;
  localparam int RND_W   = ACC_W - COEF_FRAC;

  typedef logic signed [MPROD_W-1:0] mprod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [RND_W-1:0]   rnd_t;

  // saturation bounds of one output coordinate
  localparam rnd_t RND_MAX = (rnd_t'(1) <<< (POINT_W - 1)) - rnd_t'(1);
  localparam rnd_t RND_MIN = -(rnd_t'(1) <<< (POINT_W - 1));

  angle_t angle_q [3];
  point_t shift_q [3];
  logic   build_start;
  logic   busy;
  coef_t  mat [9];

  // config writes
  logic cfg_fire;
  assign cfg_ready_o = !busy;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '{default: '0};
      shift_q <= '{default: '0};
    end else if (cfg_fire) begin
      unique case (cfg_idx_i)
        REG_ANGLE_X: angle_q[0] <= angle_t'(cfg_data_i[ANG_W-1:0]);
        REG_ANGLE_Y: angle_q[1] <= angle_t'(cfg_data_i[ANG_W-1:0]);
        REG_ANGLE_Z: angle_q[2] <= angle_t'(cfg_data_i[ANG_W-1:0]);
        REG_SHIFT_X: shift_q[0] <= point_t'(cfg_data_i);
        REG_SHIFT_Y: shift_q[1] <= point_t'(cfg_data_i);
        REG_SHIFT_Z: shift_q[2] <= point_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      build_start <= 1'b0;
    end else begin
      build_start <= cfg_fire && (cfg_idx_i == REG_ANGLE_X || cfg_idx_i == REG_ANGLE_Y ||
                                  cfg_idx_i == REG_ANGLE_Z);
    end
  end

  ertp_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (build_start),
    .angle_i (angle_q),
    .busy_o  (busy),
    .mat_o   (mat)
  );

  // pipeline flow control
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3, in_fire;
  assign adv3       = !v3_q || !out_stall_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = busy || build_start || !adv1;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_fire;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // stage 1: nine coefficient by coordinate products
  point_t pin [3];
  assign pin[0] = in_data_i.x_in;
  assign pin[1] = in_data_i.y_in;
  assign pin[2] = in_data_i.z_in;

  mprod_t prod_q [9];
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      for (int k = 0; k < 9; k++) begin
        prod_q[k] <= mprod_t'(mat[k]) * mprod_t'(pin[k % 3]);
      end
    end
  end

  // stage 2: row sums with scaled translation
  acc_t acc_q [3];
  always_ff @(posedge clk_i) begin
    if (adv2) begin
      for (int r = 0; r < 3; r++) begin
        acc_q[r] <= acc_t'(prod_q[3*r]) + acc_t'(prod_q[3*r+1]) + acc_t'(prod_q[3*r+2])
                  + (acc_t'(shift_q[r]) <<< COEF_FRAC);
      end
    end
  end

  // stage 3: round to 16 fraction bits and saturate
  rnd_t   rnd [3];
  point_t res [3];
  logic   hit [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rnd[r] = rnd_t'((acc_q[r] + acc_t'(2 ** (COEF_FRAC - 1))) >>> COEF_FRAC);
      hit[r] = 1'b0;
      res[r] = point_t'(rnd[r]);
      if (rnd[r] > RND_MAX) begin
        res[r] = {1'b0, {(POINT_W-1){1'b1}}};
        hit[r] = 1'b1;
      end else if (rnd[r] < RND_MIN) begin
        res[r] = {1'b1, {(POINT_W-1){1'b0}}};
        hit[r] = 1'b1;
      end
    end
  end

  pt_out_t out_q;
  always_ff @(posedge clk_i) begin
    if (adv3) begin
      out_q.x_out    <= res[0];
      out_q.y_out    <= res[1];
      out_q.z_out    <= res[2];
      out_q.overflow <= hit[0] | hit[1] | hit[2];
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

endmodule

[sv/ertp_matrix.sv]
// ertp_matrix: builds the 3x3 rotation matrix from three euler angles with an
// iterative cordic and one shared 18x18 multiplier; depends on ertp_pkg
module ertp_matrix import ertp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  angle_t angle_i [3],
  output logic   busy_o,
  output coef_t  mat_o [9]
);

  localparam int PROD_W  = 2 * COEF_W;
  localparam int WIDE_W  = 40;
  localparam int N_PROD  = 14;
  localparam int STEP_W  = 4;

  localparam cord_t Q30_PI      = 34'sd3373259426;
  localparam cord_t Q30_HALF_PI = 34'sd1686629713;
  localparam cord_t Q30_GAIN    = 34'sd652032874;

  typedef enum logic [2:0] {
    M_IDLE,
    M_LOAD,
    M_ROT,
    M_MUL,
    M_RND,
    M_SUM
  } mstate_e;

  typedef logic signed [WIDE_W-1:0] wide_t;

  mstate_e                  state_q;
  logic [1:0]               ang_sel_q;
  logic [ITER_W-1:0]        iter_q;
  logic [STEP_W-1:0]        step_q;
  cord_t                    x_q, y_q, z_q;
  logic                     neg_q;
  coef_t                    sin_q [3];
  coef_t                    cos_q [3];
  coef_t                    prod_q [N_PROD];
  logic signed [PROD_W-1:0] mul_q;
  coef_t                    mat_q [9];

  function automatic coef_t sat_coef(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = WIDE_W'(2 ** (COEF_W - 1) - 1);
    lo = -hi - 1;
    if (v > hi) return coef_t'(hi);
    if (v < lo) return coef_t'(lo);
    return coef_t'(v);
  endfunction

  // angle load with single pi reduction
  cord_t z_ext, z_init;
  logic  neg_init;
  always_comb begin
    z_ext = cord_t'(angle_i[ang_sel_q]) <<< 17;
    z_init = z_ext;
    neg_init = 1'b0;
    if (z_ext > Q30_HALF_PI) begin
      z_init = z_ext - Q30_PI;
      neg_init = 1'b1;
    end else if (z_ext < -Q30_HALF_PI) begin
      z_init = z_ext + Q30_PI;
      neg_init = 1'b1;
    end
  end

  // one cordic rotation
  cord_t x_sh, y_sh, atan_v, x_nx, y_nx, z_nx;
  always_comb begin
    x_sh = x_q >>> iter_q;
    y_sh = y_q >>> iter_q;
    atan_v = atan_q30(iter_q);
    if (!z_q[CORDIC_W-1]) begin
      x_nx = x_q - y_sh;
      y_nx = y_q + x_sh;
      z_nx = z_q - atan_v;
    end else begin
      x_nx = x_q + y_sh;
      y_nx = y_q - x_sh;
      z_nx = z_q + atan_v;
    end
  end

  // final rounding of the last rotation to coefficient format
  cord_t x_fin, y_fin;
  coef_t cos_rnd, sin_rnd;
  always_comb begin
    x_fin = neg_q ? -x_nx : x_nx;
    y_fin = neg_q ? -y_nx : y_nx;
    cos_rnd = sat_coef(WIDE_W'((x_fin + cord_t'(2 ** (29 - COEF_FRAC))) >>> (30 - COEF_FRAC)));
    sin_rnd = sat_coef(WIDE_W'((y_fin + cord_t'(2 ** (29 - COEF_FRAC))) >>> (30 - COEF_FRAC)));
  end

  // operand select for the shared multiplier, index 0 is x, 1 is y, 2 is z
  coef_t op_a, op_b;
  always_comb begin
    unique case (step_q)
      4'd0:    begin op_a = sin_q[0];  op_b = sin_q[1]; end
      4'd1:    begin op_a = cos_q[0];  op_b = sin_q[1]; end
      4'd2:    begin op_a = cos_q[1];  op_b = cos_q[2]; end
      4'd3:    begin op_a = cos_q[1];  op_b = sin_q[2]; end
      4'd4:    begin op_a = prod_q[0]; op_b = cos_q[2]; end
      4'd5:    begin op_a = cos_q[0];  op_b = sin_q[2]; end
      4'd6:    begin op_a = prod_q[0]; op_b = sin_q[2]; end
      4'd7:    begin op_a = cos_q[0];  op_b = cos_q[2]; end
      4'd8:    begin op_a = sin_q[0];  op_b = cos_q[1]; end
      4'd9:    begin op_a = prod_q[1]; op_b = cos_q[2]; end
      4'd10:   begin op_a = sin_q[0];  op_b = sin_q[2]; end
      4'd11:   begin op_a = prod_q[1]; op_b = sin_q[2]; end
      4'd12:   begin op_a = sin_q[0];  op_b = cos_q[2]; end
      4'd13:   begin op_a = cos_q[0];  op_b = cos_q[1]; end
      default: begin op_a = '0;        op_b = '0;       end
    endcase
  end

  coef_t mul_rnd;
  assign mul_rnd = sat_coef(WIDE_W'((mul_q + PROD_W'(2 ** (COEF_FRAC - 1))) >>> COEF_FRAC));

  // build sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= M_LOAD;
      ang_sel_q <= '0;
      iter_q    <= '0;
      step_q    <= '0;
    end else begin
      unique case (state_q)
        M_IDLE: begin
          if (start_i) begin
            state_q   <= M_LOAD;
            ang_sel_q <= '0;
          end
        end
        M_LOAD: begin
          x_q    <= Q30_GAIN;
          y_q    <= '0;
          z_q    <= z_init;
          neg_q  <= neg_init;
          iter_q <= '0;
          state_q <= M_ROT;
        end
        M_ROT: begin
          x_q    <= x_nx;
          y_q    <= y_nx;
          z_q    <= z_nx;
          iter_q <= iter_q + 1'b1;
          if (iter_q == ITER_W'(CORDIC_STEPS - 1)) begin
            sin_q[ang_sel_q] <= sin_rnd;
            cos_q[ang_sel_q] <= cos_rnd;
            if (ang_sel_q == 2'd2) begin
              step_q  <= '0;
              state_q <= M_MUL;
            end else begin
              ang_sel_q <= ang_sel_q + 1'b1;
              state_q   <= M_LOAD;
            end
          end
        end
        M_MUL: begin
          mul_q   <= op_a * op_b;
          state_q <= M_RND;
        end
        M_RND: begin
          prod_q[step_q] <= mul_rnd;
          if (step_q == STEP_W'(N_PROD - 1)) begin
            state_q <= M_SUM;
          end else begin
            step_q  <= step_q + 1'b1;
            state_q <= M_MUL;
          end
        end
        M_SUM: begin
          mat_q[0] <= prod_q[2];
          mat_q[1] <= prod_q[3];
          mat_q[2] <= sat_coef(-WIDE_W'(sin_q[1]));
          mat_q[3] <= sat_coef(WIDE_W'(prod_q[4]) - WIDE_W'(prod_q[5]));
          mat_q[4] <= sat_coef(WIDE_W'(prod_q[6]) + WIDE_W'(prod_q[7]));
          mat_q[5] <= prod_q[8];
          mat_q[6] <= sat_coef(WIDE_W'(prod_q[9]) + WIDE_W'(prod_q[10]));
          mat_q[7] <= sat_coef(WIDE_W'(prod_q[11]) - WIDE_W'(prod_q[12]));
          mat_q[8] <= prod_q[13];
          state_q  <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != M_IDLE);
  assign mat_o  = mat_q;

endmodule

[tb/tb_euler_rotate_translate_points_unit.sv]
// testbench for euler_rotate_translate_points_unit: streams points through the
// transform and checks each result against a behavioral predictor; needs ertp_pkg
module tb_euler_rotate_translate_points_unit;
  import ertp_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 160;
  localparam int N_RANDOM = 1030;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pt_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  pt_out_t out_data_o;

  euler_rotate_translate_points_unit dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  longint ang[3];
  longint shift[3];
  longint rot[9];
  pt_out_t pending_q[$];
  int errors = 0;
  int n_points = 0;
  int n_sat = 0;
  int n_cfg = 0;
  int idle_cycles = 0;

  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint HPI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30 = 64'sd652032874;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return shr_floor(v + (64'sd1 << (s - 1)), s);
  endfunction

  function automatic longint clamp(longint v, int w, ref bit hit);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // cordic sine and cosine of a q3.13 angle, in matrix format
  task automatic trig(input longint a, output longint s, output longint c);
    longint z;
    longint x;
    longint y;
    longint nx;
    bit flip;
    bit dummy;
    z = a * (64'sd1 << 17);
    x = GAIN_Q30;
    y = 0;
    flip = 1'b0;
    if (z > HPI_Q30) begin
      z -= PI_Q30;
      flip = 1'b1;
    end else if (z < -HPI_Q30) begin
      z += PI_Q30;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(atan_q30(ITER_W'(i)));
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(atan_q30(ITER_W'(i)));
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clamp(rnd_shift(x, 30 - COEF_FRAC), COEF_W, dummy);
    s = clamp(rnd_shift(y, 30 - COEF_FRAC), COEF_W, dummy);
  endtask

  function automatic longint cm(longint a, longint b);
    bit dummy;
    return clamp(rnd_shift(a * b, COEF_FRAC), COEF_W, dummy);
  endfunction

  function automatic longint cs(longint v);
    bit dummy;
    return clamp(v, COEF_W, dummy);
  endfunction

  task automatic rebuild_rotation();
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    trig(ang[0], sx, cx);
    trig(ang[1], sy, cy);
    trig(ang[2], sz, cz);
    sxsy = cm(sx, sy);
    cxsy = cm(cx, sy);
    rot[0] = cm(cy, cz);
    rot[1] = cm(cy, sz);
    rot[2] = cs(-sy);
    rot[3] = cs(cm(sxsy, cz) - cm(cx, sz));
    rot[4] = cs(cm(sxsy, sz) + cm(cx, cz));
    rot[5] = cm(sx, cy);
    rot[6] = cs(cm(cxsy, cz) + cm(sx, sz));
    rot[7] = cs(cm(cxsy, sz) - cm(sx, cz));
    rot[8] = cm(cx, cy);
  endtask

  function automatic pt_out_t transform_point(pt_in_t p);
    longint v[3];
    longint acc;
    longint r[3];
    bit hit;
    pt_out_t o;
    hit = 1'b0;
    v[0] = longint'(p.x_in);
    v[1] = longint'(p.y_in);
    v[2] = longint'(p.z_in);
    for (int k = 0; k < 3; k++) begin
      acc = rot[3*k] * v[0] + rot[3*k+1] * v[1] + rot[3*k+2] * v[2]
          + shift[k] * (64'sd1 << COEF_FRAC);
      r[k] = clamp(rnd_shift(acc, COEF_FRAC), POINT_W, hit);
    end
    o.x_out = point_t'(r[0]);
    o.y_out = point_t'(r[1]);
    o.z_out = point_t'(r[2]);
    o.overflow = hit;
    return o;
  endfunction

  // register write, predictor updated on acceptance, valid low again before return
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DAT_W-1:0] val);
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ANGLE_X, REG_ANGLE_Y, REG_ANGLE_Z: begin
        ang[int'(idx)] = longint'(angle_t'(val[ANG_W-1:0]));
        rebuild_rotation();
      end
      default: shift[int'(idx) - 3] = longint'(point_t'(val));
    endcase
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // drain all expectations, then let the matrix rebuild finish
  task automatic wait_idle();
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // one point, kept on the bus until accepted; the caller lowers valid
  task automatic send_point(pt_in_t p, bit check_typed, pt_out_t typed);
    pt_out_t e;
    in_data_i <= p;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    e = transform_point(p);
    if (check_typed && e != typed) begin
      $display("%0t typed expectation differs from predictor: exp %h got %h",
               $time, typed, e);
      errors++;
    end
    pending_q.push_back(e);
    n_points++;
    @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    pt_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (e.overflow) n_sat++;
        if (out_data_o.x_out !== e.x_out) begin
          $display("%0t x_out exp %h got %h", $time, e.x_out, out_data_o.x_out);
          errors++;
        end
        if (out_data_o.y_out !== e.y_out) begin
          $display("%0t y_out exp %h got %h", $time, e.y_out, out_data_o.y_out);
          errors++;
        end
        if (out_data_o.z_out !== e.z_out) begin
          $display("%0t z_out exp %h got %h", $time, e.z_out, out_data_o.z_out);
          errors++;
        end
        if (out_data_o.overflow !== e.overflow) begin
          $display("%0t overflow exp %b got %b", $time, e.overflow,
                   out_data_o.overflow);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern: quiet stretches alternating with random stalls
  always @(negedge clk_i) begin
    int phase;
    phase = ($time / 12) % 700;
    if (phase < 150) out_stall_i <= 1'b0;
    else if (phase < 400) out_stall_i <= ($urandom_range(0, 3) == 0);
    else out_stall_i <= ($urandom_range(0, 1) == 1);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  typedef struct {
    pt_in_t p;
    bit typed;
    pt_out_t r;
  } dir_row_t;

  function automatic pt_in_t mk(int x, int y, int z);
    pt_in_t p;
    p.x_in = x;
    p.y_in = y;
    p.z_in = z;
    return p;
  endfunction

  function automatic pt_out_t mo(int x, int y, int z, bit ov);
    pt_out_t o;
    o.x_out = x;
    o.y_out = y;
    o.z_out = z;
    o.overflow = ov;
    return o;
  endfunction

  function automatic logic [CFG_DAT_W-1:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return CFG_DAT_W'(16'sd25736);
      1: return CFG_DAT_W'(-16'sd25736);
      2: return CFG_DAT_W'($urandom_range(0, 65535));
      default: return CFG_DAT_W'(angle_t'($urandom_range(0, 51472) - 25736));
    endcase
  endfunction

  function automatic logic [CFG_DAT_W-1:0] rand_shift();
    case ($urandom_range(0, 4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return CFG_DAT_W'(int'($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
    endcase
  endfunction

  function automatic pt_in_t rand_point();
    pt_in_t p;
    p = {$urandom, $urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      // moderate coordinates most of the time so saturation stays a corner case
      p.x_in = int'($urandom_range(0, 32'h0fffffff)) - 32'sh08000000;
      p.y_in = int'($urandom_range(0, 32'h0fffffff)) - 32'sh08000000;
      p.z_in = int'($urandom_range(0, 32'h0fffffff)) - 32'sh08000000;
    end
    return p;
  endfunction

  initial begin
    dir_row_t rows[$];
    int burst;
    int sent;
    int phase_len;
    ang = '{0, 0, 0};
    shift = '{0, 0, 0};
    rebuild_rotation();

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    wait_idle();

    // directed points at reset: identity matrix, no translation
    rows.push_back('{mk(0, 0, 0), 1, mo(0, 0, 0, 0)});
    rows.push_back('{mk(32'h00010000, 32'h00020000, -32'sh00030000), 1,
                     mo(32'h00010000, 32'h00020000, -32'sh00030000, 0)});
    rows.push_back('{mk(32'h7fffffff, 32'h80000000, 32'hffffffff), 1,
                     mo(32'h7fffffff, 32'h80000000, 32'hffffffff, 0)});
    rows.push_back('{mk(32'h55555555, 32'haaaaaaaa, 32'h12345678), 0, '0});
    foreach (rows[i]) begin
      send_point(rows[i].p, rows[i].typed, rows[i].r);
    end
    in_valid_i <= 1'b0;
    wait_idle();

    // translation extremes force saturation on the identity matrix
    write_reg(REG_SHIFT_X, 32'h7fffffff);
    write_reg(REG_SHIFT_Y, 32'h80000000);
    write_reg(REG_SHIFT_Z, 32'h00000001);
    rows.delete();
    rows.push_back('{mk(32'h7fffffff, 32'h80000000, 0), 1,
                     mo(32'h7fffffff, 32'h80000000, 1, 1)});
    rows.push_back('{mk(32'h80000000, 32'h7fffffff, 32'h7fffffff), 1,
                     mo(-1, -1, 32'h7fffffff, 1)});
    rows.push_back('{mk(0, 0, 0), 0, '0});
    foreach (rows[i]) begin
      send_point(rows[i].p, rows[i].typed, rows[i].r);
    end
    in_valid_i <= 1'b0;
    wait_idle();

    // angle extremes, past +-pi/2 (pi reduction), and raw +-4 rad
    write_reg(REG_SHIFT_X, 32'h00010000);
    write_reg(REG_SHIFT_Y, 32'h0);
    write_reg(REG_SHIFT_Z, 32'hffff0000);
    write_reg(REG_ANGLE_X, CFG_DAT_W'(16'sd25736));
    write_reg(REG_ANGLE_Y, CFG_DAT_W'(-16'sd25736));
    write_reg(REG_ANGLE_Z, CFG_DAT_W'(16'sd12868));
    rows.delete();
    rows.push_back('{mk(32'h00010000, 32'h00010000, 32'h00010000), 0, '0});
    rows.push_back('{mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 0, '0});
    rows.push_back('{mk(32'h80000000, 32'h80000000, 32'h80000000), 0, '0});
    foreach (rows[i]) begin
      send_point(rows[i].p, rows[i].typed, rows[i].r);
    end
    in_valid_i <= 1'b0;
    wait_idle();
    write_reg(REG_ANGLE_X, 32'h00007fff);
    write_reg(REG_ANGLE_Y, 32'h00008000);
    write_reg(REG_ANGLE_Z, CFG_DAT_W'(-16'sd12869));
    rows.delete();
    rows.push_back('{mk(32'h00020000, -32'sh00050000, 32'h00007fff), 0, '0});
    rows.push_back('{mk(32'h40000000, 32'hc0000000, 32'h20000000), 0, '0});
    foreach (rows[i]) begin
      send_point(rows[i].p, rows[i].typed, rows[i].r);
    end
    in_valid_i <= 1'b0;
    wait_idle();

    // random phases: new settings, then bursts of points with gaps
    sent = 0;
    while (sent < N_RANDOM) begin
      if ($urandom_range(0, 1)) write_reg(REG_ANGLE_X, rand_angle());
      if ($urandom_range(0, 1)) write_reg(REG_ANGLE_Y, rand_angle());
      if ($urandom_range(0, 1)) write_reg(REG_ANGLE_Z, rand_angle());
      if ($urandom_range(0, 1)) write_reg(REG_SHIFT_X, rand_shift());
      if ($urandom_range(0, 1)) write_reg(REG_SHIFT_Y, rand_shift());
      if ($urandom_range(0, 1)) write_reg(REG_SHIFT_Z, rand_shift());
      phase_len = $urandom_range(40, 160);
      while (phase_len > 0 && sent < N_RANDOM) begin
        burst = $urandom_range(1, 24);
        for (int b = 0; b < burst && phase_len > 0; b++) begin
          send_point(rand_point(), 0, '0);
          sent++;
          phase_len--;
        end
        if ($urandom_range(0, 2) != 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 8)) @(negedge clk_i);
        end
      end
      in_valid_i <= 1'b0;
      wait_idle();
    end

    wait_idle();
    $display("%0d points checked over %0d register writes, %0d saturated results",
             n_points, n_cfg, n_sat);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
